[rtl/ncsg_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ncsg_pkg: shared types and constants of the NTSC composite sample generator
// Request and result payloads, per-sample control word, line timing marks.
// ----------------------------------------------------------------------------
package ncsg_pkg;

  // Field widths
  localparam int FUNC_W      = 1;
  localparam int PIX_IDX_W   = 9;
  localparam int PIX_VAL_W   = 16;
  localparam int DAC_W       = 6;
  localparam int LINE_W      = 9;
  localparam int SAMPLE_W    = 10;

  // Default geometry
  localparam int PIXELS_PER_LINE_DEF = 320;
  localparam int LINE_SAMPLES_DEF    = 910;
  localparam int ACTIVE_SAMPLES_DEF  = 753;
  localparam int FRAME_LINES_DEF     = 262;
  localparam int VISIBLE_LINES_DEF   = 240;

  // Horizontal timing marks (sample offsets within a line)
  localparam int FP_END       = 22;
  localparam int SYNC_END     = FP_END + 67;
  localparam int BREEZE_END   = SYNC_END + 9;
  localparam int BURST_END    = BREEZE_END + 36;
  localparam int ACT_FIRST    = BURST_END + 23;
  localparam int SERR_LEN     = 67;
  localparam int VSYNC_LINES  = 3;

  // DAC levels
  localparam logic [DAC_W-1:0] SYNC_CODE  = 6'd0;
  localparam logic [DAC_W-1:0] BLANK_CODE = 6'd18;
  localparam logic [DAC_W-1:0] BURST_LEVELS [4] = '{6'd18, 6'd9, 6'd18, 6'd27};

  // Request function codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD   = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 1'b1;

  // Chroma rotation within a 4-sample group
  typedef enum logic [1:0] {
    PH_POS_I = 2'd0,
    PH_POS_Q = 2'd1,
    PH_NEG_I = 2'd2,
    PH_NEG_Q = 2'd3
  } chroma_phase_t;

  typedef struct packed {
    logic [FUNC_W-1:0]    func;
    logic [PIX_IDX_W-1:0] pixel_index;
    logic [PIX_VAL_W-1:0] pixel_value;
  } in_item_t;

  typedef struct packed {
    logic [DAC_W-1:0]    dac_level;
    logic [LINE_W-1:0]   line_number;
    logic [SAMPLE_W-1:0] sample_index;
    logic                line_end;
  } out_item_t;

  // Control word that travels with each sample through the color pipe
  typedef struct packed {
    logic                active;
    chroma_phase_t       phase;
    logic [DAC_W-1:0]    level;
    logic [LINE_W-1:0]   line;
    logic [SAMPLE_W-1:0] sample;
    logic                line_end;
  } smp_ctrl_t;

endpackage
`default_nettype wire

[rtl/ncsg_line_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ncsg_line_store: pixel line memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ncsg_line_store import ncsg_pkg::*; #(
  parameter int DEPTH  = PIXELS_PER_LINE_DEF,
  parameter int ADDR_W = $clog2(PIXELS_PER_LINE_DEF)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  logic [PIX_VAL_W-1:0] wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_W-1:0]    rd_addr,
  output logic [PIX_VAL_W-1:0] rd_data
);

  logic [PIX_VAL_W-1:0] mem [DEPTH];
  logic [PIX_VAL_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

[rtl/ncsg_timing.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ncsg_timing: line and frame sequencer
// Sample/line counters, pixel accumulator, per-sample control word.
// ----------------------------------------------------------------------------
module ncsg_timing import ncsg_pkg::*; #(
  parameter int PIXELS_PER_LINE = PIXELS_PER_LINE_DEF,
  parameter int LINE_SAMPLES    = LINE_SAMPLES_DEF,
  parameter int ACTIVE_SAMPLES  = ACTIVE_SAMPLES_DEF,
  parameter int FRAME_LINES     = FRAME_LINES_DEF,
  parameter int VISIBLE_LINES   = VISIBLE_LINES_DEF,
  parameter int PIX_W           = $clog2(PIXELS_PER_LINE_DEF)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             smp_acc,
  output smp_ctrl_t        ctrl,
  output logic [PIX_W-1:0] rd_addr
);

  localparam int ACC_STEP = (PIXELS_PER_LINE * 65536) / ACTIVE_SAMPLES;
  localparam int ACC_W    = $clog2(PIXELS_PER_LINE) + 17;
  localparam int PXF_W    = ACC_W - 16;
  localparam int ACT_END  = ACT_FIRST + ACTIVE_SAMPLES;
  localparam int HALF     = LINE_SAMPLES / 2;

  logic [SAMPLE_W-1:0] sample_r, sample_nxt;
  logic [LINE_W-1:0]   line_r, line_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;

  logic [PXF_W-1:0]    px_full;
  logic                visible, vsync, active, last;
  logic [SAMPLE_W-1:0] act_ofs, burst_ofs;
  logic [DAC_W-1:0]    hb_level, vs_level;
  logic [LINE_W:0]     line_inc;

  // pixel pick, saturated at the last store entry
  assign px_full = acc_r[ACC_W-1:16];
  assign rd_addr = (px_full > PXF_W'(PIXELS_PER_LINE - 1)) ?
                   PIX_W'(PIXELS_PER_LINE - 1) : px_full[PIX_W-1:0];

  // line classification
  assign visible   = line_r < LINE_W'(VISIBLE_LINES);
  assign vsync     = !visible && (line_r < LINE_W'(VISIBLE_LINES + VSYNC_LINES));
  assign act_ofs   = sample_r - SAMPLE_W'(ACT_FIRST);
  assign burst_ofs = sample_r - SAMPLE_W'(BREEZE_END);
  assign active    = visible && (sample_r >= SAMPLE_W'(ACT_FIRST)) &&
                     (sample_r < SAMPLE_W'(ACT_END));
  assign last      = sample_r >= SAMPLE_W'(LINE_SAMPLES - 1);

  // horizontal blanking level
  always_comb begin
    if (sample_r < SAMPLE_W'(FP_END)) begin
      hb_level = BLANK_CODE;
    end else if (sample_r < SAMPLE_W'(SYNC_END)) begin
      hb_level = SYNC_CODE;
    end else if (sample_r < SAMPLE_W'(BREEZE_END)) begin
      hb_level = BLANK_CODE;
    end else if (sample_r < SAMPLE_W'(BURST_END)) begin
      hb_level = BURST_LEVELS[burst_ofs[1:0]];
    end else begin
      hb_level = BLANK_CODE;
    end
  end

  // vertical sync line with serration
  assign vs_level = ((sample_r >= SAMPLE_W'(HALF)) &&
                     (sample_r < SAMPLE_W'(HALF + SERR_LEN))) ? BLANK_CODE : SYNC_CODE;

  // control word for the sample taken now
  always_comb begin
    ctrl.active   = active;
    ctrl.phase    = chroma_phase_t'(act_ofs[1:0]);
    ctrl.level    = vsync ? vs_level : hb_level;
    ctrl.line     = line_r;
    ctrl.sample   = sample_r;
    ctrl.line_end = last;
  end

  // counter advance
  assign line_inc = {1'b0, line_r} + (LINE_W+1)'(1);

  always_comb begin
    sample_nxt = sample_r;
    line_nxt   = line_r;
    acc_nxt    = acc_r;
    if (smp_acc) begin
      if (last) begin
        sample_nxt = '0;
        acc_nxt    = '0;
        line_nxt   = (line_inc >= (LINE_W+1)'(FRAME_LINES)) ? '0 : line_inc[LINE_W-1:0];
      end else begin
        sample_nxt = sample_r + SAMPLE_W'(1);
        if (active) begin
          acc_nxt = acc_r + ACC_W'(ACC_STEP);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_r <= '0;
      line_r   <= '0;
      acc_r    <= '0;
    end else begin
      sample_r <= sample_nxt;
      line_r   <= line_nxt;
      acc_r    <= acc_nxt;
    end
  end

`ifndef SYNTH
  // line end wraps the sample counter and clears the accumulator
  a_line_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (smp_acc && last) |=> (sample_r == '0) && (acc_r == '0))
    else $error("line end did not restart the line");

  // inside a line the sample counter steps by one per sample request
  a_sample_step: assert property (@(posedge clk) disable iff (!rst_n)
    (smp_acc && !last) |=> (sample_r == $past(sample_r) + SAMPLE_W'(1)) &&
                           (line_r == $past(line_r)))
    else $error("sample counter did not step");
`endif

endmodule
`default_nettype wire

[rtl/ncsg_color_pipe.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ncsg_color_pipe: RGB565 to composite IRE pipeline
// Four stages: store read, YIQ sums, divide by 1000, held chroma and clamp.
// ----------------------------------------------------------------------------
module ncsg_color_pipe import ncsg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  smp_ctrl_t            in_ctrl,
  input  logic [PIX_VAL_W-1:0] rd_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output smp_ctrl_t            out_ctrl,
  output logic [7:0]           out_ire_ofs
);

  // ceil(2^28/1000): exact floor division for values below 2^18
  localparam logic [36:0] REC_1000 = 37'd268436;
  // 93 * ceil(2^24/255): y*93/255 in one step
  localparam logic [31:0] REC_LUMA = 32'd6118842;

  // stage valids and ready chain
  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // stage 1: control aligned with the store read data
  smp_ctrl_t c1_r;

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      c1_r <= in_ctrl;
    end
  end

  // stage 2: weighted sums
  logic [7:0]         r8, g8, b8;
  logic signed [18:0] rs, gs, bs;
  logic [17:0]        ysum_c;
  logic signed [18:0] isum_c, qsum_c;
  smp_ctrl_t          c2_r;
  logic [17:0]        ysum2_r;
  logic signed [18:0] isum2_r, qsum2_r;

  assign r8 = {rd_data[15:11], 3'b000};
  assign g8 = {rd_data[10:5], 2'b00};
  assign b8 = {rd_data[4:0], 3'b000};
  assign rs = $signed({11'd0, r8});
  assign gs = $signed({11'd0, g8});
  assign bs = $signed({11'd0, b8});

  assign ysum_c = 18'({10'd0, r8}) * 18'd299 + 18'({10'd0, g8}) * 18'd587 +
                  18'({10'd0, b8}) * 18'd114;
  assign isum_c = rs * 19'sd596 - gs * 19'sd274 - bs * 19'sd322;
  assign qsum_c = rs * 19'sd211 - gs * 19'sd523 + bs * 19'sd312;

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      c2_r    <= c1_r;
      ysum2_r <= ysum_c;
      isum2_r <= isum_c;
      qsum2_r <= qsum_c;
    end
  end

  // stage 3: truncating divide by 1000
  function automatic logic [8:0] div1000(input logic [17:0] x);
    logic [36:0] p;
    p = 37'(x) * REC_1000;
    return p[36:28];
  endfunction

  function automatic logic signed [9:0] sdiv1000(input logic signed [18:0] x);
    logic [17:0]        mag;
    logic signed [9:0]  q;
    mag = x[18] ? 18'(-x) : 18'(x);
    q   = $signed({1'b0, div1000(mag)});
    return x[18] ? -q : q;
  endfunction

  logic [8:0]        yq_c;
  smp_ctrl_t         c3_r;
  logic [7:0]        y3_r;
  logic signed [9:0] i3_r, q3_r;

  assign yq_c = div1000(ysum2_r);

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      c3_r <= c2_r;
      y3_r <= yq_c[7:0];
      i3_r <= sdiv1000(isum2_r);
      q3_r <= sdiv1000(qsum2_r);
    end
  end

  // stage 4: luma scale, eighths, chroma rotation, clamp
  function automatic logic signed [5:0] eighth(input logic signed [9:0] x);
    logic [9:0]        mag;
    logic signed [5:0] e;
    mag = x[9] ? 10'(-x) : 10'(x);
    e   = $signed(6'(mag >> 3));
    return x[9] ? -e : e;
  endfunction

  logic [31:0]        luma_p;
  logic [6:0]         luma_n, luma_cur;
  logic signed [5:0]  i8_n, q8_n, i8_cur, q8_cur;
  logic               load;
  logic signed [8:0]  chroma, ire;
  logic [7:0]         ofs_c;
  logic [6:0]         held_luma_r;
  logic signed [5:0]  held_i_r, held_q_r;
  smp_ctrl_t          c4_r;
  logic [7:0]         ofs4_r;

  assign luma_p = 32'(y3_r) * REC_LUMA;
  assign luma_n = 7'(luma_p[30:24]) + 7'd7;
  assign i8_n   = eighth(i3_r);
  assign q8_n   = eighth(q3_r);
  assign load   = c3_r.active && (c3_r.phase == PH_POS_I);

  assign luma_cur = load ? luma_n : held_luma_r;
  assign i8_cur   = load ? i8_n : held_i_r;
  assign q8_cur   = load ? q8_n : held_q_r;

  always_comb begin
    case (c3_r.phase)
      PH_POS_I: chroma = 9'(i8_cur);
      PH_POS_Q: chroma = 9'(q8_cur);
      PH_NEG_I: chroma = -9'(i8_cur);
      PH_NEG_Q: chroma = -9'(q8_cur);
      default:  chroma = '0;
    endcase
  end

  assign ire = $signed({2'b00, luma_cur}) + chroma;

  always_comb begin
    if (ire < -9'sd40) begin
      ofs_c = 8'd0;
    end else if (ire > 9'sd100) begin
      ofs_c = 8'd140;
    end else begin
      ofs_c = 8'(ire + 9'sd40);
    end
  end

  // held pixel values, loaded at the first sample of each active group
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_luma_r <= '0;
      held_i_r    <= '0;
      held_q_r    <= '0;
    end else if (rdy4 && v3_r && load) begin
      held_luma_r <= luma_n;
      held_i_r    <= i8_n;
      held_q_r    <= q8_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      c4_r   <= c3_r;
      ofs4_r <= ofs_c;
    end
  end

  assign out_valid   = v4_r;
  assign out_ctrl    = c4_r;
  assign out_ire_ofs = ofs4_r;

`ifndef SYNTH
  // a full pipe only while the downstream side is stalled
  a_pipe_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (v1_r && v2_r && v3_r && v4_r && !out_ready))
    else $error("color pipe stalled with a free stage");
`endif

endmodule
`default_nettype wire

[rtl/ntsc_composite_sample_generator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ntsc_composite_sample_generator: NTSC 4fsc composite sample generator
// 240p composite video samples from a host-loaded RGB565 line store.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : valid/ready request channel. func = load writes pixel_value into
//           the line store at pixel_index (indexes past the line are
//           dropped) and gives no result. func = sample requests the next
//           DAC sample of the frame and gives exactly one result.
//   out_* : valid/ready result channel: DAC code, line, sample position and
//           a last-sample-of-line flag.
// Throughput is one request per cycle while in_ready is high. A sample result
// is registered in order by the store read, YIQ sums, divide by 1000 and
// chroma/clamp stages, then by the output register with the DAC scale.
// When the receiver stalls, requests keep being taken until the four pipe
// stages and the output register are full; then in_ready drops.
// Reset clears the counters, the held pixel values and all valids; the
// line store has no reset and must be loaded before it is displayed.
// ----------------------------------------------------------------------------
module ntsc_composite_sample_generator import ncsg_pkg::*; #(
  parameter int PIXELS_PER_LINE = PIXELS_PER_LINE_DEF,
  parameter int LINE_SAMPLES    = LINE_SAMPLES_DEF,
  parameter int ACTIVE_SAMPLES  = ACTIVE_SAMPLES_DEF,
  parameter int FRAME_LINES     = FRAME_LINES_DEF,
  parameter int VISIBLE_LINES   = VISIBLE_LINES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int PIX_W = $clog2(PIXELS_PER_LINE);

  // DAC scale: ceil(2^20/140) * 63
  localparam logic [26:0] REC_DAC = 27'd471870;

  logic             req_acc, smp_acc, wr_en;
  logic [PIX_W-1:0] rd_addr;
  smp_ctrl_t        tm_ctrl, pipe_ctrl;
  logic [PIX_VAL_W-1:0] rd_data;
  logic             pipe_valid, pipe_ready, out_free;
  logic [7:0]       pipe_ofs;
  logic [26:0]      dac_p;
  logic             out_valid_r;
  out_item_t        out_data_r;

  assign req_acc = in_valid && in_ready;
  assign smp_acc = req_acc && (in_data.func == FUNC_SAMPLE);
  assign wr_en   = req_acc && (in_data.func == FUNC_LOAD) &&
                   (int'(in_data.pixel_index) < PIXELS_PER_LINE);

  // line and frame sequencer
  ncsg_timing #(
    .PIXELS_PER_LINE (PIXELS_PER_LINE),
    .LINE_SAMPLES    (LINE_SAMPLES),
    .ACTIVE_SAMPLES  (ACTIVE_SAMPLES),
    .FRAME_LINES     (FRAME_LINES),
    .VISIBLE_LINES   (VISIBLE_LINES),
    .PIX_W           (PIX_W)
  ) u_timing (
    .clk     (clk),
    .rst_n   (rst_n),
    .smp_acc (smp_acc),
    .ctrl    (tm_ctrl),
    .rd_addr (rd_addr)
  );

  // line store
  ncsg_line_store #(
    .DEPTH  (PIXELS_PER_LINE),
    .ADDR_W (PIX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (PIX_W'(in_data.pixel_index)),
    .wr_data (in_data.pixel_value),
    .rd_en   (smp_acc),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // color pipeline
  ncsg_color_pipe u_pipe (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (smp_acc),
    .in_ready    (pipe_ready),
    .in_ctrl     (tm_ctrl),
    .rd_data     (rd_data),
    .out_valid   (pipe_valid),
    .out_ready   (out_free),
    .out_ctrl    (pipe_ctrl),
    .out_ire_ofs (pipe_ofs)
  );

  assign in_ready = pipe_ready;

  // output register with DAC scale
  assign out_free = !out_valid_r || out_ready;
  assign dac_p    = 27'(pipe_ofs) * REC_DAC;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= pipe_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && pipe_valid) begin
      out_data_r.dac_level    <= pipe_ctrl.active ? dac_p[25:20] : pipe_ctrl.level;
      out_data_r.line_number  <= pipe_ctrl.line;
      out_data_r.sample_index <= pipe_ctrl.sample;
      out_data_r.line_end     <= pipe_ctrl.line_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  // line end flag only on the last sample position
  a_line_end_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.line_end) |->
      (out_data.sample_index == SAMPLE_W'(LINE_SAMPLES - 1)))
    else $error("line end flag on wrong sample");

  // frame line stays inside the frame
  a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.line_number < LINE_W'(FRAME_LINES)))
    else $error("line number past frame end");

  // a result follows the line end with sample zero of the next line
  a_line_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_data.line_end) |=>
      (!out_valid || (out_data.sample_index == '0)))
    else $error("next line did not start at sample zero");
`endif

endmodule
`default_nettype wire
